@@ sv/fprx_pkg.sv @@
package fprx_pkg;

  // Payload store geometry.
  localparam int PAYLOAD_DEPTH = 64;
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  // Field and register widths.
  localparam int BYTE_W = 8;
  localparam int LEN_W = 7;
  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [BYTE_W-1:0] START_ONE_RST = 8'd85;
  localparam logic [BYTE_W-1:0] START_TWO_RST = 8'd170;
  localparam logic [BYTE_W-1:0] ACK_CODE_RST = 8'd6;
  localparam logic [BYTE_W-1:0] NACK_CODE_RST = 8'd21;
  localparam logic [LEN_W-1:0] MIN_LEN_RST = 7'd1;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd64;
  localparam logic [BYTE_W-1:0] SEED_RST = 8'd0;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ONE = 3'd0,
    CFG_START_TWO = 3'd1,
    CFG_ACK_CODE  = 3'd2,
    CFG_NACK_CODE = 3'd3,
    CFG_MIN_LEN   = 3'd4,
    CFG_MAX_LEN   = 3'd5,
    CFG_SEED      = 3'd6,
    CFG_TIMEOUT   = 3'd7
  } cfg_reg_e;

  // Frame parser phase.
  typedef enum logic [1:0] {
    PH_SOF1 = 2'd0,
    PH_SOF2 = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_NONE    = 3'd0,
    STAT_ACK     = 3'd1,
    STAT_NACK    = 3'd2,
    STAT_GOOD    = 3'd3,
    STAT_ERR     = 3'd4,
    STAT_TIMEOUT = 3'd5
  } status_e;

  // Reply request codes.
  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_ACK  = 2'd1,
    RPL_NACK = 2'd2
  } reply_e;

  // Emission sequencer state.
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_SEND = 2'd2
  } emit_e;

  // Decision of the parser for the word on the input port.
  typedef struct packed {
    logic              res_en;
    status_e           status;
    reply_e            reply;
    logic              run_start;
    logic [ADDR_W-1:0] run_len;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } fprx_dec_t;

endpackage

@@ sv/fprx_parse.sv @@
module fprx_parse (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic                                   action_i,
  input  logic [fprx_pkg::BYTE_W-1:0]            rx_byte_i,
  input  logic                                   cfg_we_i,
  input  logic [fprx_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [fprx_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  output fprx_pkg::fprx_dec_t                    dec_o
);
  import fprx_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0] start_one_q, start_two_q, ack_code_q, nack_code_q, seed_q;
  logic [LEN_W-1:0]  min_len_q, max_len_q;
  logic [TICK_W-1:0] timeout_q;

  // Parser state.
  phase_e            phase_q, phase_d;
  logic              active_q, active_d, active_pre;
  logic [ADDR_W-1:0] plen_q, plen_d;
  logic [ADDR_W-1:0] count_q, count_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;

  // Conditions on the current word.
  logic is_byte;
  logic sof1_start, ack_hit, nack_hit;
  logic sof2_ok, sof2_bad;
  logic len_bad, len_ok;
  logic data_store, data_close, sum_ok;
  logic early_res, timeout_hit;

  assign is_byte    = !action_i;
  assign sof1_start = is_byte && (phase_q == PH_SOF1) && (rx_byte_i == start_one_q);
  assign ack_hit    = is_byte && (phase_q == PH_SOF1) && (rx_byte_i != start_one_q) &&
                      (rx_byte_i == ack_code_q);
  assign nack_hit   = is_byte && (phase_q == PH_SOF1) && (rx_byte_i != start_one_q) &&
                      (rx_byte_i != ack_code_q) && (rx_byte_i == nack_code_q);
  assign sof2_ok    = is_byte && (phase_q == PH_SOF2) && (rx_byte_i == start_two_q);
  assign sof2_bad   = is_byte && (phase_q == PH_SOF2) && (rx_byte_i != start_two_q);
  assign len_bad    = is_byte && (phase_q == PH_LEN) &&
                      ((rx_byte_i > {1'b0, max_len_q}) || (rx_byte_i < {1'b0, min_len_q}) ||
                       (rx_byte_i > BYTE_W'(PAYLOAD_DEPTH)));
  assign len_ok     = is_byte && (phase_q == PH_LEN) && !len_bad;
  assign data_store = is_byte && (phase_q == PH_DATA) && (count_q < plen_q);
  assign data_close = is_byte && (phase_q == PH_DATA) && !(count_q < plen_q);
  assign sum_ok     = (xor_q == rx_byte_i);

  // Every one of these produces a result or a payload run of its own.
  assign early_res   = ack_hit || nack_hit || sof2_bad || len_bad || data_close;
  assign timeout_hit = !early_res && active_pre && (elapsed_d >= timeout_q);
  assign active_d    = active_pre && !timeout_hit;

  // Counters, checksum and the activity flag.
  always_comb begin
    elapsed_d  = elapsed_q;
    active_pre = active_q;
    plen_d     = plen_q;
    count_d    = count_q;
    xor_d      = xor_q;
    if (!is_byte) begin
      if (elapsed_q != '1) begin
        elapsed_d = elapsed_q + 1'b1;
      end
    end
    if (sof1_start) begin
      active_pre = 1'b1;
      elapsed_d  = '0;
    end
    if (sof2_ok) begin
      elapsed_d = '0;
    end
    if (len_ok) begin
      // A zero length byte behaves as a frame with only a checksum.
      plen_d    = (rx_byte_i == '0) ? '0 : ADDR_W'(rx_byte_i - 1'b1);
      xor_d     = seed_q;
      count_d   = '0;
      elapsed_d = '0;
    end
    if (data_store) begin
      xor_d     = xor_q ^ rx_byte_i;
      count_d   = count_q + 1'b1;
      elapsed_d = '0;
    end
    if (data_close) begin
      active_pre = 1'b0;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_SOF1: begin
        if (sof1_start) phase_d = PH_SOF2;
      end
      PH_SOF2: begin
        if (sof2_ok) phase_d = PH_LEN;
        else if (sof2_bad) phase_d = PH_SOF1;
      end
      PH_LEN: begin
        if (len_ok) phase_d = PH_DATA;
        else if (len_bad) phase_d = PH_SOF1;
      end
      PH_DATA: begin
        if (data_close) phase_d = PH_SOF1;
      end
      default: phase_d = PH_SOF1;
    endcase
    if (timeout_hit) begin
      phase_d = PH_SOF1;
    end
  end

  // Decision for the word: a single result, a payload run, a store write.
  always_comb begin
    dec_o           = '0;
    dec_o.status    = STAT_NONE;
    dec_o.reply     = RPL_NONE;
    dec_o.wr_en     = data_store;
    dec_o.wr_addr   = count_q;
    dec_o.wr_data   = rx_byte_i;
    dec_o.run_len   = plen_q;
    if (ack_hit) begin
      dec_o.res_en = 1'b1;
      dec_o.status = STAT_ACK;
    end else if (nack_hit) begin
      dec_o.res_en = 1'b1;
      dec_o.status = STAT_NACK;
    end else if (sof2_bad || len_bad || (data_close && !sum_ok)) begin
      dec_o.res_en = 1'b1;
      dec_o.status = STAT_ERR;
      dec_o.reply  = RPL_NACK;
    end else if (data_close && (plen_q == '0)) begin
      dec_o.res_en = 1'b1;
      dec_o.status = STAT_GOOD;
      dec_o.reply  = RPL_ACK;
    end else if (data_close) begin
      dec_o.run_start = 1'b1;
    end else if (timeout_hit) begin
      dec_o.res_en = 1'b1;
      dec_o.status = STAT_TIMEOUT;
      dec_o.reply  = RPL_NACK;
    end
  end

  // Parser state registers, updated on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SOF1;
      active_q  <= 1'b0;
      plen_q    <= '0;
      count_q   <= '0;
      xor_q     <= '0;
      elapsed_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      active_q  <= active_d;
      plen_q    <= plen_d;
      count_q   <= count_d;
      xor_q     <= xor_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_one_q <= START_ONE_RST;
      start_two_q <= START_TWO_RST;
      ack_code_q  <= ACK_CODE_RST;
      nack_code_q <= NACK_CODE_RST;
      min_len_q   <= MIN_LEN_RST;
      max_len_q   <= MAX_LEN_RST;
      seed_q      <= SEED_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_START_ONE: start_one_q <= cfg_wdata_i[BYTE_W-1:0];
        CFG_START_TWO: start_two_q <= cfg_wdata_i[BYTE_W-1:0];
        CFG_ACK_CODE:  ack_code_q  <= cfg_wdata_i[BYTE_W-1:0];
        CFG_NACK_CODE: nack_code_q <= cfg_wdata_i[BYTE_W-1:0];
        CFG_MIN_LEN:   min_len_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_MAX_LEN:   max_len_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_SEED:      seed_q      <= cfg_wdata_i[BYTE_W-1:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Assertions.
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dec_o.res_en && dec_o.run_start))
    else $error("parser asked for a result and a run at once");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.wr_en |-> (dec_o.wr_addr < plen_q))
    else $error("payload write beyond frame length");

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && timeout_hit) |=> (!active_q && phase_q == PH_SOF1))
    else $error("timeout did not return the parser to idle");

endmodule

@@ sv/framed_packet_receiver_xor_core.sv @@
// Channel | Direction | Handshake                 | Word
// input   | in        | in_valid_i / in_stall_o   | action_i, rx_byte_i
// output  | out       | out_valid_o / out_stall_i | status_o, reply_o, payload_byte_o, last_o
// config  | in        | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// A byte or tick is taken every cycle while no run is in progress and the output register is free.
// A good frame with N payload bytes then emits its run one byte at a time:
// each byte is read from the payload RAM, then sent once the output register is free.
// Reset clears control state and loads register defaults; the payload RAM is
// not cleared, since only bytes written in the current frame are read back.
// in_stall_o is high during a run and while a stalled result fills the output.
module framed_packet_receiver_xor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [fprx_pkg::BYTE_W-1:0]         rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic [1:0]                          reply_o,
  output logic [fprx_pkg::BYTE_W-1:0]         payload_byte_o,
  output logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [fprx_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fprx_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import fprx_pkg::*;

  fprx_dec_t dec;

  emit_e             em_q, em_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] len_q, len_d;
  logic              run_last;

  logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic              mem_we;

  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  reply_e            reply_q, reply_d;
  logic [BYTE_W-1:0] payload_q, payload_d;
  logic              last_q, last_d;
  logic              out_free, in_fire, load_single, load_run;

  // Handshakes.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((em_q == EM_IDLE) && out_free);
  assign in_fire    = in_valid_i && !in_stall_o;

  fprx_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .action_i    (action_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .dec_o       (dec)
  );

  // Payload RAM: one write port from the parser, one registered read port.
  assign mem_we = in_fire && dec.wr_en;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      payload_mem[dec.wr_addr] <= dec.wr_data;
    end
    rd_data_q <= payload_mem[idx_q];
  end

  assign run_last = (idx_q == len_q - 1'b1);

  // Sequencer next state.
  always_comb begin
    em_d = em_q;
    case (em_q)
      EM_IDLE: begin
        if (in_fire && dec.run_start) em_d = EM_READ;
      end
      EM_READ: em_d = EM_SEND;
      EM_SEND: begin
        if (out_free) em_d = run_last ? EM_IDLE : EM_READ;
      end
      default: em_d = EM_IDLE;
    endcase
  end

  // Sequencer outputs: run index and output register loads.
  always_comb begin
    idx_d       = idx_q;
    len_d       = len_q;
    load_single = 1'b0;
    load_run    = 1'b0;
    case (em_q)
      EM_IDLE: begin
        load_single = in_fire && dec.res_en;
        if (in_fire && dec.run_start) begin
          idx_d = '0;
          len_d = dec.run_len;
        end
      end
      EM_READ: ;
      EM_SEND: begin
        load_run = out_free;
        if (out_free && !run_last) idx_d = idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register contents.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    reply_d     = reply_q;
    payload_d   = payload_q;
    last_d      = last_q;
    if (load_single) begin
      out_valid_d = 1'b1;
      status_d    = dec.status;
      reply_d     = dec.reply;
      payload_d   = '0;
      last_d      = 1'b1;
    end else if (load_run) begin
      out_valid_d = 1'b1;
      status_d    = STAT_GOOD;
      reply_d     = run_last ? RPL_ACK : RPL_NONE;
      payload_d   = rd_data_q;
      last_d      = run_last;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_q        <= EM_IDLE;
      idx_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      em_q        <= em_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word registers.
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    reply_q   <= reply_d;
    payload_q <= payload_d;
    last_q    <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign reply_o        = reply_q;
  assign payload_byte_o = payload_q;
  assign last_o         = last_q;

  // Assertions.
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && dec.run_start) |-> (dec.run_len != '0))
    else $error("payload run started with no bytes");

  a_read_then_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_q == EM_READ) |=> (em_q == EM_SEND))
    else $error("RAM read not followed by send");

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_q != EM_IDLE) |-> (idx_q < len_q))
    else $error("run index beyond run length");

  a_run_ends_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((em_q == EM_SEND) && out_free && run_last) |=>
      (out_valid_q && last_q && reply_q == RPL_ACK && em_q == EM_IDLE))
    else $error("payload run did not end with an ACK word");

endmodule
